FILE: rtl/core/mvsm_pkg.sv
package mvsm_pkg;

  // Action codes carried by an input item
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_MIX   = 2'd3
  } action_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START_ATT,
    ST_START_GL,
    ST_START_GR,
    ST_START_FIN,
    ST_CHECK,
    ST_DIV,
    ST_GL,
    ST_GR,
    ST_L1,
    ST_L2,
    ST_LG,
    ST_R2,
    ST_LM,
    ST_RM,
    ST_ACC,
    ST_RESP
  } state_t;

  // Shared multiplier operand widths
  localparam int MUL_AW = 34;
  localparam int MUL_BW = 28;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Gains: 65536 stands for 1.0
  localparam logic [16:0] UNITY    = 17'd65536;
  localparam logic [13:0] PAN_FULL = 14'd10000;

  // round(mag*65536/10000) = floor((mag*8192 + 625) / 1250),
  // done as a multiply by ceil(2^37/1250) and a shift by 37
  localparam logic [26:0] ATT_RECIP = 27'd109951163;
  localparam logic [9:0]  ATT_BIAS  = 10'd625;
  localparam int          ATT_SHIFT = 37;

  // Configuration register index
  localparam logic REG_MASTER = 1'b0;

  // Saturate a 24-bit signed value to Q1.15
  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/mvsm_if.sv
// Command channel: one item per handshake
interface mvsm_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [3:0]         voice;
  logic [15:0]        sample_addr;
  logic signed [15:0] sample_value;
  logic [15:0]        length_frames;
  logic               stereo;
  logic [23:0]        step;
  logic signed [14:0] pan;
  logic [16:0]        volume;
  logic               loop;

  modport source (
    output valid, action, voice, sample_addr, sample_value, length_frames,
           stereo, step, pan, volume, loop,
    input  ready
  );
  modport sink (
    input  valid, action, voice, sample_addr, sample_value, length_frames,
           stereo, step, pan, volume, loop,
    output ready
  );
endinterface

// Result channel
interface mvsm_res_if;
  logic               valid;
  logic               ready;
  logic               frame_valid;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic [15:0]        finished_mask;

  modport source (
    output valid, frame_valid, out_left, out_right, finished_mask,
    input  ready
  );
  modport sink (
    input  valid, frame_valid, out_left, out_right, finished_mask,
    output ready
  );
endinterface

FILE: rtl/core/mvsm_mul.sv
// Shared signed multiplier, product registered
module mvsm_mul (
  input  logic                                 clk,
  input  logic signed [mvsm_pkg::MUL_AW-1:0]   a,
  input  logic signed [mvsm_pkg::MUL_BW-1:0]   b,
  output logic signed [mvsm_pkg::MUL_PW-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: rtl/core/mvsm_smem.sv
// Sample memory: one write port, one registered read port
module mvsm_smem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/multi_voice_sample_mixer_core.sv
// Write and stop items go straight from idle to the result state; start items
// first pass the attenuation, gain and finish states. A mix item checks each voice
// in turn; a looping voice that wraps first runs the serial remainder, and every
// playing voice then takes 8 products on the single shared multiplier.
// One item at a time; the next item is taken while a result still waits.
// Synchronous reset clears voice play state, cursors and master volume (1.0).
module multi_voice_sample_mixer_core #(
  parameter int VOICES       = 16,
  parameter int SAMPLE_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  mvsm_cmd_if.sink    cmd,
  mvsm_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int KW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW = $clog2(SAMPLE_WORDS);

  // Configuration port
  logic [16:0] master;
  logic [16:0] mv;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      master <= mvsm_pkg::UNITY;
    end else if (psel && penable && pwrite && paddr[2] == mvsm_pkg::REG_MASTER) begin
      master <= pwdata[16:0];
    end
  end

  assign prdata = (paddr[2] == mvsm_pkg::REG_MASTER) ? {15'd0, master} : 32'd0;
  assign mv     = (master > mvsm_pkg::UNITY) ? mvsm_pkg::UNITY : master;

  // Voice state
  logic [VOICES-1:0] playing;
  logic [31:0]       cursor  [VOICES];
  logic [15:0]       v_base  [VOICES];
  logic [15:0]       v_len   [VOICES];
  logic [23:0]       v_step  [VOICES];
  logic [16:0]       v_gl    [VOICES];
  logic [16:0]       v_gr    [VOICES];
  logic [1:0]        v_flags [VOICES];

  // Sequencer and working registers
  mvsm_pkg::state_t   state, state_next;
  logic [KW-1:0]      k;
  logic [15:0]        fin_mask;
  logic signed [55:0] sum_l, sum_r;
  logic               is_mix;
  logic [31:0]        wcur;
  logic [15:0]        dq;
  logic [16:0]        rem;
  logic [3:0]         dcnt;
  logic [16:0]        gl_e, gr_e;
  logic signed [15:0] s1, s2;
  logic signed [31:0] pacc, pl, pr;

  // Start item latches
  logic [KW-1:0]      st_v;
  logic [15:0]        st_base, st_len;
  logic [1:0]         st_flags;
  logic [23:0]        st_step;
  logic [16:0]        st_vol;
  logic [13:0]        st_mag;
  logic               st_pos, st_neg;
  logic [16:0]        sg_r;

  // Shared multiplier and sample memory
  logic signed [mvsm_pkg::MUL_AW-1:0] mul_a;
  logic signed [mvsm_pkg::MUL_BW-1:0] mul_b;
  logic signed [mvsm_pkg::MUL_PW-1:0] prod;
  logic [AW-1:0] raddr;
  logic [15:0]   rdata;
  logic          mem_we;
  logic [24:0]   waddr_x;

  mvsm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  mvsm_smem #(.DEPTH(SAMPLE_WORDS), .AW(AW)) u_smem (
    .clk(clk), .we(mem_we), .waddr(waddr_x[AW-1:0]), .wdata(cmd.sample_value),
    .raddr(raddr), .rdata(rdata)
  );

  logic       acc;
  logic [6:0] vx;
  logic       v_ok;
  logic [6:0] kx;

  assign cmd.ready = (state == mvsm_pkg::ST_IDLE);
  assign acc       = cmd.valid && cmd.ready;
  assign vx        = {3'd0, cmd.voice};
  assign v_ok      = (vx < 7'(VOICES));
  assign kx        = 7'(k);
  assign mem_we    = acc && (cmd.action == mvsm_pkg::ACT_WRITE);
  assign waddr_x   = 25'(cmd.sample_addr);

  // Pan magnitude and volume at acceptance
  logic signed [15:0] pan_x;
  logic [15:0]        pan_abs;
  logic [13:0]        mag_in;
  logic [16:0]        vol_in;

  assign pan_x   = 16'(cmd.pan);
  assign pan_abs = pan_x[15] ? 16'(-pan_x) : pan_x;
  assign mag_in  = (pan_abs > 16'(mvsm_pkg::PAN_FULL)) ? mvsm_pkg::PAN_FULL : pan_abs[13:0];
  assign vol_in  = (cmd.volume > mvsm_pkg::UNITY) ? mvsm_pkg::UNITY : cmd.volume;

  // Current voice view
  logic [15:0] len_k;
  logic [31:0] cur_k;
  logic        stereo_k;
  logic [15:0] i1, i2, fr;
  logic [16:0] i1p;
  logic [16:0] one_minus_f;

  assign len_k       = v_len[k];
  assign cur_k       = cursor[k];
  assign stereo_k    = v_flags[k][0];
  assign i1          = wcur[31:16];
  assign fr          = wcur[15:0];
  assign i1p         = {1'b0, i1} + 17'd1;
  assign i2          = (i1p >= {1'b0, len_k}) ? i1 : i1p[15:0];
  assign one_minus_f = mvsm_pkg::UNITY - {1'b0, fr};

  function automatic logic [24:0] word_addr(input logic [15:0] base, input logic [15:0] idx,
                                             input logic st, input logic side);
    logic [24:0] off;
    off = st ? ({8'd0, idx, 1'b0} + 25'(side)) : 25'(idx);
    return 25'(base) + off;
  endfunction

  logic [24:0] a1l, a2l, a1r, a2r;
  assign a1l = word_addr(v_base[k], i1, stereo_k, 1'b0);
  assign a2l = word_addr(v_base[k], i2, stereo_k, 1'b0);
  assign a1r = word_addr(v_base[k], i1, stereo_k, 1'b1);
  assign a2r = word_addr(v_base[k], i2, stereo_k, 1'b1);

  // Serial remainder step
  logic [16:0] rem_t, rem_n;
  assign rem_t = {rem[15:0], dq[15]};
  assign rem_n = (rem_t >= {1'b0, len_k}) ? rem_t - {1'b0, len_k} : rem_t;

  // Pan attenuation from the reciprocal product
  localparam int ATT_HI = mvsm_pkg::ATT_SHIFT + 16;
  logic [16:0] att, sg_att;
  assign att    = prod[ATT_HI:mvsm_pkg::ATT_SHIFT];
  assign sg_att = mvsm_pkg::UNITY - att;

  logic [26:0] att_num;
  assign att_num = {st_mag, 13'd0} + 27'(mvsm_pkg::ATT_BIAS);

  logic last_k;
  assign last_k = (k == KW'(VOICES - 1));

  // Next state, multiplier operands, read address
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    raddr      = a1l[AW-1:0];
    unique case (state)
      mvsm_pkg::ST_IDLE: begin
        if (acc) begin
          priority if (cmd.action == mvsm_pkg::ACT_START && v_ok) begin
            state_next = mvsm_pkg::ST_START_ATT;
          end else if (cmd.action == mvsm_pkg::ACT_MIX) begin
            state_next = mvsm_pkg::ST_CHECK;
          end else begin
            state_next = mvsm_pkg::ST_RESP;
          end
        end
      end
      mvsm_pkg::ST_START_ATT: begin
        mul_a      = mvsm_pkg::MUL_AW'(att_num);
        mul_b      = mvsm_pkg::MUL_BW'(mvsm_pkg::ATT_RECIP);
        state_next = mvsm_pkg::ST_START_GL;
      end
      mvsm_pkg::ST_START_GL: begin
        mul_a      = mvsm_pkg::MUL_AW'(st_vol);
        mul_b      = mvsm_pkg::MUL_BW'(st_pos ? sg_att : mvsm_pkg::UNITY);
        state_next = mvsm_pkg::ST_START_GR;
      end
      mvsm_pkg::ST_START_GR: begin
        mul_a      = mvsm_pkg::MUL_AW'(st_vol);
        mul_b      = mvsm_pkg::MUL_BW'(sg_r);
        state_next = mvsm_pkg::ST_START_FIN;
      end
      mvsm_pkg::ST_START_FIN: begin
        state_next = mvsm_pkg::ST_RESP;
      end
      mvsm_pkg::ST_CHECK: begin
        if (!playing[k] || len_k == 16'd0 ||
            (cur_k[31:16] >= len_k && !v_flags[k][1])) begin
          state_next = last_k ? mvsm_pkg::ST_RESP : mvsm_pkg::ST_CHECK;
        end else if (cur_k[31:16] >= len_k) begin
          state_next = mvsm_pkg::ST_DIV;
        end else begin
          state_next = mvsm_pkg::ST_GL;
        end
      end
      mvsm_pkg::ST_DIV: begin
        if (dcnt == 4'd0) begin
          state_next = mvsm_pkg::ST_GL;
        end
      end
      mvsm_pkg::ST_GL: begin
        mul_a      = mvsm_pkg::MUL_AW'(mv);
        mul_b      = mvsm_pkg::MUL_BW'(v_gl[k]);
        raddr      = a1l[AW-1:0];
        state_next = mvsm_pkg::ST_GR;
      end
      mvsm_pkg::ST_GR: begin
        mul_a      = mvsm_pkg::MUL_AW'(mv);
        mul_b      = mvsm_pkg::MUL_BW'(v_gr[k]);
        raddr      = a2l[AW-1:0];
        state_next = mvsm_pkg::ST_L1;
      end
      mvsm_pkg::ST_L1: begin
        mul_a      = mvsm_pkg::MUL_AW'(s1);
        mul_b      = mvsm_pkg::MUL_BW'(one_minus_f);
        raddr      = a1r[AW-1:0];
        state_next = mvsm_pkg::ST_L2;
      end
      mvsm_pkg::ST_L2: begin
        mul_a      = mvsm_pkg::MUL_AW'(s2);
        mul_b      = mvsm_pkg::MUL_BW'({1'b0, fr});
        raddr      = a2r[AW-1:0];
        state_next = mvsm_pkg::ST_LG;
      end
      mvsm_pkg::ST_LG: begin
        mul_a      = mvsm_pkg::MUL_AW'(s1);
        mul_b      = mvsm_pkg::MUL_BW'(one_minus_f);
        state_next = mvsm_pkg::ST_R2;
      end
      mvsm_pkg::ST_R2: begin
        mul_a      = mvsm_pkg::MUL_AW'(s2);
        mul_b      = mvsm_pkg::MUL_BW'({1'b0, fr});
        state_next = mvsm_pkg::ST_LM;
      end
      mvsm_pkg::ST_LM: begin
        mul_a      = mvsm_pkg::MUL_AW'(pl);
        mul_b      = mvsm_pkg::MUL_BW'(gl_e);
        state_next = mvsm_pkg::ST_RM;
      end
      mvsm_pkg::ST_RM: begin
        mul_a      = mvsm_pkg::MUL_AW'(pr);
        mul_b      = mvsm_pkg::MUL_BW'(gr_e);
        state_next = mvsm_pkg::ST_ACC;
      end
      mvsm_pkg::ST_ACC: begin
        state_next = last_k ? mvsm_pkg::ST_RESP : mvsm_pkg::ST_CHECK;
      end
      mvsm_pkg::ST_RESP: begin
        if (!res.valid || res.ready) begin
          state_next = mvsm_pkg::ST_IDLE;
        end
      end
      default: state_next = mvsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mvsm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Cursor advance with saturation
  logic [32:0] nxt;
  assign nxt = {1'b0, wcur} + 33'(v_step[k]);

  logic signed [32:0] psum;
  assign psum = 33'(pacc) + 33'(prod[31:0]);

  // Voice state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      playing <= '0;
      for (int i = 0; i < VOICES; i++) begin
        cursor[i] <= 32'd0;
      end
    end else begin
      unique case (state)
        mvsm_pkg::ST_IDLE: begin
          if (acc && cmd.action == mvsm_pkg::ACT_STOP && v_ok) begin
            playing[vx[KW-1:0]] <= 1'b0;
          end
        end
        mvsm_pkg::ST_START_FIN: begin
          v_base[st_v]  <= st_base;
          v_len[st_v]   <= st_len;
          v_flags[st_v] <= st_flags;
          v_step[st_v]  <= st_step;
          v_gr[st_v]    <= prod[32:16];
          cursor[st_v]  <= 32'd0;
          playing[st_v] <= 1'b1;
        end
        mvsm_pkg::ST_START_GR: begin
          v_gl[st_v] <= prod[32:16];
        end
        mvsm_pkg::ST_CHECK: begin
          if (playing[k] && len_k != 16'd0 && cur_k[31:16] >= len_k && !v_flags[k][1]) begin
            playing[k] <= 1'b0;
            cursor[k]  <= 32'd0;
          end
        end
        mvsm_pkg::ST_ACC: begin
          cursor[k] <= nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      mvsm_pkg::ST_IDLE: begin
        if (acc) begin
          is_mix   <= (cmd.action == mvsm_pkg::ACT_MIX);
          k        <= '0;
          fin_mask <= 16'd0;
          sum_l    <= '0;
          sum_r    <= '0;
          st_v     <= vx[KW-1:0];
          st_base  <= cmd.sample_addr;
          st_len   <= cmd.length_frames;
          st_flags <= {cmd.loop, cmd.stereo};
          st_step  <= cmd.step;
          st_vol   <= vol_in;
          st_mag   <= mag_in;
          st_pos   <= !pan_x[15] && pan_x != 16'sd0;
          st_neg   <= pan_x[15];
        end
      end
      mvsm_pkg::ST_START_GL: begin
        sg_r <= st_neg ? sg_att : mvsm_pkg::UNITY;
      end
      mvsm_pkg::ST_CHECK: begin
        wcur <= cur_k;
        dq   <= cur_k[31:16];
        rem  <= 17'd0;
        dcnt <= 4'd15;
        if (!playing[k] || len_k == 16'd0 ||
            (cur_k[31:16] >= len_k && !v_flags[k][1])) begin
          if (playing[k] && len_k != 16'd0 && kx < 7'd16) begin
            fin_mask[kx[3:0]] <= 1'b1;
          end
          if (!last_k) begin
            k <= k + KW'(1);
          end
        end
      end
      mvsm_pkg::ST_DIV: begin
        rem  <= rem_n;
        dq   <= {dq[14:0], 1'b0};
        dcnt <= dcnt - 4'd1;
        if (dcnt == 4'd0) begin
          wcur <= {rem_n[15:0], wcur[15:0]};
        end
      end
      mvsm_pkg::ST_GR: begin
        gl_e <= prod[32:16];
        s1   <= rdata;
      end
      mvsm_pkg::ST_L1: begin
        gr_e <= prod[32:16];
        s2   <= rdata;
      end
      mvsm_pkg::ST_L2: begin
        pacc <= prod[31:0];
        s1   <= rdata;
      end
      mvsm_pkg::ST_LG: begin
        pl <= psum[31:0];
        s2 <= rdata;
      end
      mvsm_pkg::ST_R2: begin
        pacc <= prod[31:0];
      end
      mvsm_pkg::ST_LM: begin
        pr <= psum[31:0];
      end
      mvsm_pkg::ST_RM: begin
        sum_l <= sum_l + prod[55:0];
      end
      mvsm_pkg::ST_ACC: begin
        sum_r <= sum_r + prod[55:0];
        if (!last_k) begin
          k <= k + KW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  logic load;
  assign load = (state == mvsm_pkg::ST_RESP) && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.frame_valid   <= is_mix;
      res.out_left      <= is_mix ? mvsm_pkg::sat16(sum_l[55:32]) : 16'sd0;
      res.out_right     <= is_mix ? mvsm_pkg::sat16(sum_r[55:32]) : 16'sd0;
      res.finished_mask <= is_mix ? fin_mask : 16'd0;
    end
  end

endmodule

FILE: rtl/core/mvsm_checker.sv
// Port-level checks on the mixer core
module mvsm_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic               frame_valid,
  input logic signed [15:0] out_left,
  input logic signed [15:0] out_right,
  input logic [15:0]        finished_mask
);

  // One item in flight: ready drops right after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while previous item still in work");

  // A non-mix result carries zeros
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && !frame_valid |-> out_left == 16'sd0 && out_right == 16'sd0 &&
                                  finished_mask == 16'd0)
    else $error("non-frame result with nonzero payload");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_left) && $stable(out_right) &&
                                $stable(finished_mask) && $stable(frame_valid))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind multi_voice_sample_mixer_core mvsm_checker u_mvsm_checker (
  .clk(clk),
  .rst(rst),
  .cmd_valid(cmd.valid),
  .cmd_ready(cmd.ready),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .frame_valid(res.frame_valid),
  .out_left(res.out_left),
  .out_right(res.out_right),
  .finished_mask(res.finished_mask)
);
